[rtl/chm_pkg.sv]
package chm_pkg;

  localparam int CAPACITY_DEF = 4096;
  localparam int BUCKETS_DEF  = 1024;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_VALUE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                clear_wr;
    logic                accept;
    logic                head_rd;
    logic                insert_wr;
    logic                entry_rd_head;
    logic                entry_rd_link;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                res_hit;
    logic                out_load;
  } chm_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic is_find;
    logic value_present;
    logic full;
    logic head_valid;
    logic key_match;
    logic link_valid;
    logic out_free;
  } chm_stat_t;

endpackage

[rtl/chm_ctrl.sv]
module chm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chm_pkg::chm_stat_t stat,
  output chm_pkg::chm_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_HEAD   = 3'd3;
  localparam logic [2:0] S_ENTRY  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.mod_done) begin
          // no-value check ranks above the full check
          if (!stat.is_find && !stat.value_present) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = chm_pkg::ST_NO_VALUE;
            state_nxt      = S_RESULT;
          end else if (!stat.is_find && stat.full) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = chm_pkg::ST_FULL;
            state_nxt      = S_RESULT;
          end else begin
            cmd.head_rd = 1'b1;
            state_nxt   = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (!stat.is_find) begin
          cmd.insert_wr  = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = chm_pkg::ST_INSERTED;
          state_nxt      = S_RESULT;
        end else if (stat.head_valid) begin
          cmd.entry_rd_head = 1'b1;
          state_nxt         = S_ENTRY;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = chm_pkg::ST_MISS;
          state_nxt      = S_RESULT;
        end
      end
      S_ENTRY: begin
        if (stat.key_match) begin
          cmd.res_set    = 1'b1;
          cmd.res_hit    = 1'b1;
          cmd.res_status = chm_pkg::ST_FOUND;
          state_nxt      = S_RESULT;
        end else if (stat.link_valid) begin
          cmd.entry_rd_link = 1'b1;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = chm_pkg::ST_MISS;
          state_nxt      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/chm_datapath.sv]
module chm_datapath #(
  parameter int CAPACITY = chm_pkg::CAPACITY_DEF,
  parameter int BUCKETS  = chm_pkg::BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chm_pkg::chm_cmd_t             cmd,
  output chm_pkg::chm_stat_t            stat,
  input  logic                          in_command,
  input  logic [chm_pkg::KEY_W-1:0]     in_key,
  input  logic [chm_pkg::VAL_W-1:0]     in_value,
  input  logic                          in_value_present,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [chm_pkg::STATUS_W-1:0]  out_status,
  output logic [chm_pkg::VAL_W-1:0]     out_found_value
);

  localparam int KW      = chm_pkg::KEY_W;
  localparam int VW      = chm_pkg::VAL_W;
  localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW    = $clog2(CAPACITY + 1);
  localparam int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int HW      = AW + 1;
  localparam int EW      = KW + VW + HW;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic                         command_r;
  logic [KW-1:0]                key_r;
  logic [VW-1:0]                value_r;
  logic                         present_r;
  logic [CNTW-1:0]              count_r;
  logic [BW-1:0]                clr_addr_r;
  logic [HW-1:0]                head_q_r;
  logic [EW-1:0]                entry_q_r;
  logic [chm_pkg::STATUS_W-1:0] res_status_r;
  logic [VW-1:0]                res_value_r;
  logic                         out_valid_r;
  logic [chm_pkg::STATUS_W-1:0] out_status_r;
  logic [VW-1:0]                out_found_value_r;

  logic [BW-1:0] bucket;
  logic          mod_done;
  logic [KW-1:0] q_key;
  logic [VW-1:0] q_value;
  logic          q_link_valid;
  logic [AW-1:0] q_link;
  logic [AW-1:0] rd_addr;

  logic [HW-1:0] head_mem  [BUCKETS];
  logic [EW-1:0] entry_mem [CAPACITY];

  // entry word: key, value, link valid, link slot
  assign q_key        = entry_q_r[EW-1 -: KW];
  assign q_value      = entry_q_r[HW +: VW];
  assign q_link_valid = entry_q_r[AW];
  assign q_link       = entry_q_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      command_r <= in_command;
      key_r     <= in_key;
      value_r   <= in_value;
      present_r <= in_value_present;
    end
  end

  // bucket index: key mod BUCKETS
  if (IS_POW2) begin : g_pow2
    assign bucket   = BW'(key_r & KW'(BUCKETS - 1));
    assign mod_done = 1'b1;
  end else begin : g_div
    // floor(2^(KW+SH) / BUCKETS) fits KW bits; the quotient estimate is low by
    // at most one, so one compare and subtract finishes the remainder
    localparam int SH = $clog2(BUCKETS) - 1;
    localparam logic [2*KW-1:0] RECIP_W = ((2*KW)'(1) << (KW + SH)) / (2*KW)'(BUCKETS);
    localparam logic [KW-1:0]   RECIP   = RECIP_W[KW-1:0];

    logic [2*KW-1:0] prod_r;
    logic [BW:0]     rem_est_r;
    logic [BW-1:0]   rem_r;
    logic [1:0]      mod_cnt_r;
    logic [KW-1:0]   q_est;
    logic [KW-1:0]   diff;

    assign q_est = KW'(prod_r >> (KW + SH));
    assign diff  = key_r - q_est * KW'(BUCKETS);

    // three registered steps from key_r to the remainder
    always_ff @(posedge clk) begin
      prod_r    <= (2*KW)'(key_r) * (2*KW)'(RECIP);
      rem_est_r <= diff[BW:0];
      if (rem_est_r >= (BW + 1)'(BUCKETS)) begin
        rem_r <= BW'(rem_est_r - (BW + 1)'(BUCKETS));
      end else begin
        rem_r <= rem_est_r[BW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mod_cnt_r <= '0;
      end else if (cmd.accept) begin
        mod_cnt_r <= 2'd3;
      end else if (mod_cnt_r != '0) begin
        mod_cnt_r <= mod_cnt_r - 2'd1;
      end
    end

    assign bucket   = rem_r;
    assign mod_done = (mod_cnt_r == '0);
  end

  // bucket head table
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      head_mem[clr_addr_r] <= '0;
    end else if (cmd.insert_wr) begin
      head_mem[bucket] <= {1'b1, AW'(count_r)};
    end
    if (cmd.head_rd) begin
      head_q_r <= head_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr_r <= clr_addr_r + BW'(1);
    end
  end

  // entry store; new entry links to the old head
  assign rd_addr = cmd.entry_rd_head ? head_q_r[AW-1:0] : q_link;

  always_ff @(posedge clk) begin
    if (cmd.insert_wr) begin
      entry_mem[AW'(count_r)] <= {key_r, value_r, head_q_r};
    end
    if (cmd.entry_rd_head || cmd.entry_rd_link) begin
      entry_q_r <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert_wr) begin
      count_r <= count_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= cmd.res_hit ? q_value : '0;
    end
    if (cmd.out_load) begin
      out_status_r      <= res_status_r;
      out_found_value_r <= res_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_value_r;

  assign stat.clear_last    = (clr_addr_r == BW'(BUCKETS - 1));
  assign stat.mod_done      = mod_done;
  assign stat.is_find       = (command_r == chm_pkg::CMD_FIND);
  assign stat.value_present = present_r;
  assign stat.full          = (count_r >= CNTW'(CAPACITY));
  assign stat.head_valid    = head_q_r[AW];
  assign stat.key_match     = (q_key == key_r);
  assign stat.link_valid    = q_link_valid;
  assign stat.out_free      = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert_wr |-> (count_r < CNTW'(CAPACITY)))
    else $error("insert into full store");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert_wr |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("entry count did not advance on insert");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_link_follow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.entry_rd_link |-> (q_link_valid && (q_key != key_r)))
    else $error("chain walk past end or past a hit");
`endif

endmodule

[rtl/chained_hash_map.sv]
// chained_hash_map: key to value map with separate chaining.
// input channel (in_valid/in_ready): one word carries in_command (insert or
// find), in_key, in_value and in_value_present. result channel
// (out_valid/out_ready): one word per input word with out_status and
// out_found_value.
// an insert pushes a new entry onto the head of chain (key mod BUCKETS);
// a find walks that chain from the head and returns the newest match.
// words are handled one at a time. a find follows the chain one link at a
// time, since every link is one registered read of the entry memory; an
// insert with no value or into a full store is dropped. out_valid rises
// together with in_ready. with BUCKETS not a power of two the key first
// passes through the remainder unit before the head table is read.
// after reset the bucket head table is swept empty, one entry per cycle;
// in_ready stays low during the sweep. the entry store is not cleared.
// a finished word sits in the output register; while the receiver stalls
// the block holds the next result back and takes no new word once it is
// ready to deliver.
module chained_hash_map #(
  parameter int CAPACITY = chm_pkg::CAPACITY_DEF,
  parameter int BUCKETS  = chm_pkg::BUCKETS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [chm_pkg::KEY_W-1:0]    in_key,
  input  logic [chm_pkg::VAL_W-1:0]    in_value,
  input  logic                         in_value_present,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [chm_pkg::STATUS_W-1:0] out_status,
  output logic [chm_pkg::VAL_W-1:0]    out_found_value
);

  chm_pkg::chm_cmd_t  cmd;
  chm_pkg::chm_stat_t stat;

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chm_datapath #(
    .CAPACITY (CAPACITY),
    .BUCKETS  (BUCKETS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_value         (in_value),
    .in_value_present (in_value_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_value  (out_found_value)
  );

endmodule
